/* rtl/sfnh_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sfnh_pkg
// Shared types, character codes and byte classes for the SQL fingerprint
// normalizer with FNV-1a 64-bit hash.
// ----------------------------------------------------------------------------
package sfnh_pkg;

	// configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_COLLAPSE_WS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_REPLACE_LIT = 1'd1;

	// queue between front and back
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// byte codes
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_QMARK  = 8'h3F;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_LE     = 8'h65;
	localparam logic [7:0] CH_UE     = 8'h45;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_DQUOTE = 8'h22;

	localparam logic [63:0] FNV_OFFSET = 64'hCBF2_9CE4_8422_2325;

	typedef struct packed {
		logic       cmd;
		logic [7:0] char_in;
	} in_item_t;

	typedef struct packed {
		logic [7:0]  out_byte;
		logic        is_hash;
		logic [63:0] hash_value;
		logic        last;
	} out_item_t;

	// up to four fingerprint bytes of one word, plus the end marker
	typedef struct packed {
		logic [3:0][7:0] bytes;
		logic [2:0]      cnt;
		logic            is_end;
	} bundle_t;

	typedef struct packed {
		logic    valid;
		bundle_t bundle;
	} q_entry_t;

	function automatic logic is_quote(input logic [7:0] c);
		return (c == CH_SQUOTE) || (c == CH_DQUOTE);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	function automatic logic is_ws(input logic [7:0] c);
		return (c == CH_SPACE) || ((c >= 8'h09) && (c <= 8'h0D));
	endfunction

	function automatic logic is_num_tail(input logic [7:0] c);
		return is_digit(c) || (c == CH_DOT) || (c == CH_LE) || (c == CH_UE);
	endfunction

endpackage
`default_nettype wire

/* rtl/sfnh_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sfnh_front
// Input side: config registers, whitespace collapsing and literal
// replacement; packs the resulting bytes of each word into one queue entry.
// ----------------------------------------------------------------------------
module sfnh_front (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire sfnh_pkg::in_item_t             in_data,
	input  wire logic                           cfg_we,
	input  wire logic [sfnh_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic                           cfg_data,
	input  wire logic                           q_full,
	output sfnh_pkg::q_entry_t                  q_push
);

	typedef enum logic [1:0] {LM_NORMAL, LM_STRING, LM_CLOSED, LM_SKIP} lit_mode_t;

	typedef struct packed {
		lit_mode_t  mode;
		logic [7:0] quote;
		logic       in_num;
		logic       minus;
	} lit_state_t;

	typedef struct packed {
		lit_state_t      st;
		logic [1:0][7:0] b;
		logic [1:0]      n;
	} lit_res_t;

	// one byte through the literal pass; at most two bytes out
	function automatic lit_res_t lit_feed(input lit_state_t s, input logic [7:0] c,
		input logic en);
		lit_res_t r;
		logic     done;
		r = '{st: s, b: '0, n: 2'd0};
		done = 1'b0;
		if (!en) begin
			r.b[0] = c;
			r.n = 2'd1;
		end else begin
			case (s.mode)
				LM_STRING: begin
					done = 1'b1;
					if (c == s.quote) r.st.mode = LM_CLOSED;
				end
				LM_CLOSED: begin
					if (c == s.quote) begin
						r.st.mode = LM_STRING;
						done = 1'b1;
					end else begin
						r.st.mode = LM_NORMAL;
					end
				end
				LM_SKIP: begin
					if (sfnh_pkg::is_num_tail(c)) done = 1'b1;
					else r.st.mode = LM_NORMAL;
				end
				default: ;
			endcase
			if (!done && r.st.minus) begin
				r.st.minus = 1'b0;
				if (sfnh_pkg::is_digit(c)) begin
					if (!r.st.in_num) begin
						r.b[r.n[0]] = sfnh_pkg::CH_QMARK;
						r.n = r.n + 2'd1;
						r.st.in_num = 1'b1;
					end
					r.st.mode = LM_SKIP;
					done = 1'b1;
				end else begin
					r.st.in_num = 1'b0;
					r.b[r.n[0]] = sfnh_pkg::CH_MINUS;
					r.n = r.n + 2'd1;
				end
			end
			if (!done) begin
				if (sfnh_pkg::is_quote(c)) begin
					r.b[r.n[0]] = sfnh_pkg::CH_QMARK;
					r.n = r.n + 2'd1;
					r.st.mode = LM_STRING;
					r.st.quote = c;
				end else if (sfnh_pkg::is_digit(c)) begin
					if (!r.st.in_num) begin
						r.b[r.n[0]] = sfnh_pkg::CH_QMARK;
						r.n = r.n + 2'd1;
						r.st.in_num = 1'b1;
					end
					r.st.mode = LM_SKIP;
				end else if (c == sfnh_pkg::CH_MINUS) begin
					r.st.minus = 1'b1;
				end else begin
					r.st.in_num = 1'b0;
					r.b[r.n[0]] = c;
					r.n = r.n + 2'd1;
				end
			end
		end
		return r;
	endfunction

	localparam lit_state_t LIT_RESET = '{mode: LM_NORMAL, quote: 8'h00, in_num: 1'b0,
		minus: 1'b0};

	logic       collapse_q, replace_q;
	logic       ws_mode_q, ws_prev_space_q, ws_pending_q;
	logic [7:0] ws_quote_q;
	lit_state_t lit_q;

	logic       ws_mode_d, ws_prev_space_d, ws_pending_d;
	logic [7:0] ws_quote_d;
	lit_state_t lit_d;
	logic [1:0][7:0] w_b;
	logic [1:0]      w_n;
	lit_res_t   la, lb;
	lit_state_t la_st;
	logic [1:0] na, nb;
	sfnh_pkg::bundle_t bnd;
	logic [7:0] c;
	logic       accept;

	assign c        = in_data.char_in;
	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;

	// whitespace pass: up to two bytes (a held space, then the byte)
	always_comb begin
		ws_mode_d       = ws_mode_q;
		ws_quote_d      = ws_quote_q;
		ws_prev_space_d = ws_prev_space_q;
		ws_pending_d    = ws_pending_q;
		w_b = '0;
		w_n = 2'd0;
		if (!collapse_q) begin
			w_b[0] = c;
			w_n = 2'd1;
		end else if (ws_mode_q) begin
			if (c == sfnh_pkg::CH_SPACE && c != ws_quote_q) begin
				if (ws_pending_q) begin
					w_b[0] = sfnh_pkg::CH_SPACE;
					w_n = 2'd1;
				end
				ws_pending_d = 1'b1;
			end else begin
				if (ws_pending_q) begin
					ws_pending_d = 1'b0;
					w_b[0] = sfnh_pkg::CH_SPACE;
					w_n = 2'd1;
				end
				w_b[w_n[0]] = c;
				w_n = w_n + 2'd1;
				if (c == ws_quote_q) begin
					ws_mode_d = 1'b0;
					ws_prev_space_d = 1'b0;
				end
			end
		end else if (sfnh_pkg::is_ws(c) && !sfnh_pkg::is_quote(c)) begin
			if (!ws_prev_space_q) begin
				ws_pending_d = 1'b1;
				ws_prev_space_d = 1'b1;
			end
		end else begin
			if (ws_pending_q) begin
				ws_pending_d = 1'b0;
				w_b[0] = sfnh_pkg::CH_SPACE;
				w_n = 2'd1;
			end
			w_b[w_n[0]] = c;
			w_n = w_n + 2'd1;
			ws_prev_space_d = 1'b0;
			if (sfnh_pkg::is_quote(c)) begin
				ws_mode_d = 1'b1;
				ws_quote_d = c;
			end
		end
	end

	// literal pass over the whitespace bytes, then pack into one entry
	always_comb begin
		la    = lit_feed(lit_q, w_b[0], replace_q);
		na    = (w_n != 2'd0) ? la.n : 2'd0;
		la_st = (w_n != 2'd0) ? la.st : lit_q;
		lb    = lit_feed(la_st, w_b[1], replace_q);
		nb    = (w_n == 2'd2) ? lb.n : 2'd0;
		lit_d = (w_n == 2'd2) ? lb.st : la_st;
		bnd = '0;
		bnd.bytes[0] = la.b[0];
		bnd.bytes[1] = la.b[1];
		for (int i = 0; i < 2; i++) begin
			if (2'(i) < nb) bnd.bytes[2'(na) + 2'(i)] = lb.b[i];
		end
		bnd.cnt = 3'(na) + 3'(nb);
		bnd.is_end = 1'b0;
		if (in_data.cmd) begin
			// end word: a held minus goes out before the hash
			bnd = '0;
			bnd.is_end = 1'b1;
			bnd.bytes[0] = sfnh_pkg::CH_MINUS;
			bnd.cnt = (replace_q && lit_q.minus) ? 3'd1 : 3'd0;
		end
	end

	assign q_push.valid  = accept && (in_data.cmd || bnd.cnt != 3'd0);
	assign q_push.bundle = bnd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			collapse_q      <= 1'b1;
			replace_q       <= 1'b1;
			ws_mode_q       <= 1'b0;
			ws_quote_q      <= 8'h00;
			ws_prev_space_q <= 1'b1;
			ws_pending_q    <= 1'b0;
			lit_q           <= LIT_RESET;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					sfnh_pkg::CFG_COLLAPSE_WS: collapse_q <= cfg_data;
					sfnh_pkg::CFG_REPLACE_LIT: replace_q <= cfg_data;
					default: ;
				endcase
			end
			if (accept) begin
				if (in_data.cmd) begin
					ws_mode_q       <= 1'b0;
					ws_quote_q      <= 8'h00;
					ws_prev_space_q <= 1'b1;
					ws_pending_q    <= 1'b0;
					lit_q           <= LIT_RESET;
				end else begin
					ws_mode_q       <= ws_mode_d;
					ws_quote_q      <= ws_quote_d;
					ws_prev_space_q <= ws_prev_space_d;
					ws_pending_q    <= ws_pending_d;
					lit_q           <= lit_d;
				end
			end
		end
	end

endmodule
`default_nettype wire

/* rtl/sfnh_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sfnh_queue
// Small register FIFO of byte bundles between front and back.
// ----------------------------------------------------------------------------
module sfnh_queue (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire sfnh_pkg::q_entry_t push,
	output logic                    full,
	input  wire logic               pop,
	output sfnh_pkg::q_entry_t      head
);

	sfnh_pkg::bundle_t mem_q [sfnh_pkg::QDEPTH];
	logic [sfnh_pkg::QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [sfnh_pkg::QCNT_W-1:0] count_q;

	function automatic logic [sfnh_pkg::QPTR_W-1:0] ptr_inc(
		input logic [sfnh_pkg::QPTR_W-1:0] p);
		if (p == sfnh_pkg::QPTR_W'(sfnh_pkg::QDEPTH - 1)) return '0;
		return p + 1'b1;
	endfunction

	assign full        = (count_q == sfnh_pkg::QCNT_W'(sfnh_pkg::QDEPTH));
	assign head.valid  = (count_q != '0);
	assign head.bundle = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push.valid) mem_q[wr_ptr_q] <= push.bundle;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push.valid) wr_ptr_q <= ptr_inc(wr_ptr_q);
			if (pop) rd_ptr_q <= ptr_inc(rd_ptr_q);
			if (push.valid && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push.valid) count_q <= count_q - 1'b1;
		end
	end

endmodule
`default_nettype wire

/* rtl/sfnh_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sfnh_back
// Output side: walks the bytes of the head bundle one per cycle while not
// stalled, through upper-casing and the FNV-1a hash, then emits the hash word.
// ----------------------------------------------------------------------------
module sfnh_back (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire sfnh_pkg::q_entry_t  head,
	output logic                     pop,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output sfnh_pkg::out_item_t      out_data
);

	// x * 0x100000001B3 mod 2^64, as shifts and adds
	function automatic logic [63:0] fnv_mul(input logic [63:0] x);
		return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
	endfunction

	logic [2:0]  idx_q;
	logic        case_mode_q;
	logic [7:0]  case_quote_q;
	logic [63:0] hash_q;
	logic        out_valid_q;
	sfnh_pkg::out_item_t out_q;

	logic       load, step, byte_step;
	logic [7:0] c, b;

	assign load      = !out_valid_q || !out_stall;
	assign step      = head.valid && load;
	assign byte_step = (idx_q < head.bundle.cnt);
	assign c         = head.bundle.bytes[idx_q[1:0]];
	assign b         = (!case_mode_q && c >= 8'h61 && c <= 8'h7A) ? c - 8'h20 : c;

	// pop on the last byte of a plain bundle, or on the hash word
	assign pop = step && (byte_step ? (!head.bundle.is_end && idx_q + 3'd1 == head.bundle.cnt)
		: 1'b1);

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk) begin
		if (step) begin
			if (byte_step) out_q <= '{out_byte: b, is_hash: 1'b0, hash_value: 64'd0, last: 1'b0};
			else out_q <= '{out_byte: 8'h00, is_hash: 1'b1, hash_value: hash_q, last: 1'b1};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q        <= 3'd0;
			case_mode_q  <= 1'b0;
			case_quote_q <= 8'h00;
			hash_q       <= sfnh_pkg::FNV_OFFSET;
			out_valid_q  <= 1'b0;
		end else begin
			if (load) out_valid_q <= step;
			if (step) begin
				if (byte_step) begin
					idx_q <= pop ? 3'd0 : idx_q + 3'd1;
					hash_q <= fnv_mul(hash_q ^ {56'd0, b});
					if (!case_mode_q) begin
						if (sfnh_pkg::is_quote(c)) begin
							case_mode_q <= 1'b1;
							case_quote_q <= c;
						end
					end else if (c == case_quote_q) begin
						case_mode_q <= 1'b0;
					end
				end else begin
					idx_q        <= 3'd0;
					hash_q       <= sfnh_pkg::FNV_OFFSET;
					case_mode_q  <= 1'b0;
					case_quote_q <= 8'h00;
				end
			end
		end
	end

endmodule
`default_nettype wire

/* rtl/sql_fingerprint_normalizer_hash.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sql_fingerprint_normalizer_hash
// SQL statement fingerprint: whitespace collapsing, literal replacement,
// upper-casing, and the FNV-1a 64-bit hash of the fingerprint bytes.
// ----------------------------------------------------------------------------
//
//  port group   dir  handshake           word
//  -----------  ---  ------------------  ------------------------------------
//  in_*         in   in_valid/in_stall   cmd, char_in (statement byte or end)
//  out_*        out  out_valid/out_stall out_byte, is_hash, hash_value, last
//  cfg_*        in   cfg_we              index 0 collapse ws, 1 replace lits
//
//  Input takes one word per cycle while in_stall is low; in_stall rises
//  only when the four-entry bundle queue is full. The back emits one result
//  per cycle while out_stall is low; a word yields 0 to 4 results and the
//  output handshake sets the sustained rate. A result is registered in the
//  queue, then in the output register. Reset: both config bits set, all passes
//  at statement start, hash at the offset basis, queue empty. No clearing pass.
//
//  Front: config, whitespace and literal passes update per accepted word and
//  push a bundle of bytes (plus end marker) into the queue. Back: case pass
//  and hash, one byte per cycle while not stalled, into the output register.
// ----------------------------------------------------------------------------
module sql_fingerprint_normalizer_hash (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire sfnh_pkg::in_item_t             in_data,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output sfnh_pkg::out_item_t                 out_data,
	input  wire logic                           cfg_we,
	input  wire logic [sfnh_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic                           cfg_data
);

	sfnh_pkg::q_entry_t q_push, q_head;
	logic q_full, q_pop;

	sfnh_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_full    (q_full),
		.q_push    (q_push)
	);

	sfnh_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.full   (q_full),
		.pop    (q_pop),
		.head   (q_head)
	);

	sfnh_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (q_head),
		.pop       (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	// never push into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push.valid |-> !q_full)
		else $error("push into full queue");

	// back pops only a present entry
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_head.valid)
		else $error("pop from empty queue");

	// hash word carries last and no byte
	a_hash_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.is_hash |-> out_data.last && out_data.out_byte == 8'h00)
		else $error("malformed hash word");

	// byte words never carry last
	a_byte_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.is_hash |-> !out_data.last && out_data.hash_value == 64'd0)
		else $error("malformed byte word");

endmodule
`default_nettype wire
